[design/slxff_pkg.sv]
// ----------------------------------------------------------------------------
// slxff_pkg: shared types and constants of the sync/length/XOR frame filter
// Holds the byte constants, the controller state type and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package slxff_pkg;

  localparam int unsigned MaxFrameLen = 64;
  localparam logic [7:0]  SyncByte    = 8'h55;
  localparam logic [7:0]  MinLen      = 8'd4;
  // bytes of a frame that are not payload: sync, length, checksum
  localparam logic [7:0]  HdrBytes    = 8'd3;

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_LEN,
    ST_DATA,
    ST_CSUM,
    ST_E_SYNC,
    ST_E_LEN,
    ST_E_RD,
    ST_E_PAY,
    ST_E_CSUM
  } state_e;

  typedef enum logic [1:0] {
    OSEL_SYNC,
    OSEL_LEN,
    OSEL_RAM,
    OSEL_XOR
  } out_sel_e;

  typedef struct packed {
    logic     len_ld;
    logic     data_ld;
    logic     idx_clr;
    logic     idx_inc;
    logic     rd_en;
    logic     out_ld;
    out_sel_e osel;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic len_short;
    logic data_done;
    logic csum_ok;
    logic pay_last;
    logic out_free;
  } sts_t;

endpackage

[design/slxff_ram.sv]
// ----------------------------------------------------------------------------
// slxff_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slxff_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/slxff_dp.sv]
// ----------------------------------------------------------------------------
// slxff_dp: datapath of the frame filter
// Frame length, payload count, running XOR, payload RAM, replay index and the
// output word register.
// ----------------------------------------------------------------------------
module slxff_dp #(
  parameter int unsigned MAX_FRAME_LEN = slxff_pkg::MaxFrameLen
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slxff_pkg::cmd_t    cmd_i,
  output slxff_pkg::sts_t    sts_o,
  input  logic [7:0]         rx_byte_i,
  output logic               frame_valid_o,
  input  logic               frame_ready_i,
  output logic [7:0]         frame_byte_o,
  output logic               frame_last_o
);

  localparam int unsigned AddrW = $clog2(MAX_FRAME_LEN);

  logic [7:0]       len_q, cnt_q, xor_q;
  logic             ovs_q;
  logic [AddrW-1:0] idx_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q, out_valid_q;
  logic [7:0]       ram_rdata;
  logic [7:0]       pay_len;
  logic [7:0]       out_mux;

  assign pay_len = len_q - slxff_pkg::HdrBytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      cnt_q <= '0;
      xor_q <= '0;
      ovs_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (cmd_i.len_ld) begin
        len_q <= rx_byte_i;
        cnt_q <= '0;
        xor_q <= slxff_pkg::SyncByte ^ rx_byte_i;
        ovs_q <= {1'b0, rx_byte_i} > 9'(MAX_FRAME_LEN);
      end
      if (cmd_i.data_ld) begin
        cnt_q <= cnt_q + 8'd1;
        xor_q <= xor_q ^ rx_byte_i;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AddrW'(1);
      end
    end
  end

  // store payload only for frames that fit; the count stays below the depth then
  slxff_ram #(
    .Width (8),
    .Depth (MAX_FRAME_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.data_ld && !ovs_q),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    unique case (cmd_i.osel)
      slxff_pkg::OSEL_SYNC: out_mux = slxff_pkg::SyncByte;
      slxff_pkg::OSEL_LEN:  out_mux = len_q;
      slxff_pkg::OSEL_RAM:  out_mux = ram_rdata;
      slxff_pkg::OSEL_XOR:  out_mux = xor_q;
      default:              out_mux = xor_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (frame_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_byte_q <= out_mux;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign sts_o.sync_hit  = rx_byte_i == slxff_pkg::SyncByte;
  assign sts_o.len_short = rx_byte_i < slxff_pkg::MinLen;
  assign sts_o.data_done = (9'(cnt_q) + 9'd1) >= 9'(pay_len);
  assign sts_o.csum_ok   = !ovs_q && (xor_q == rx_byte_i);
  assign sts_o.pay_last  = (8'(idx_q) + 8'd1) == pay_len;
  assign sts_o.out_free  = !out_valid_q || frame_ready_i;

  assign frame_valid_o = out_valid_q;
  assign frame_byte_o  = out_byte_q;
  assign frame_last_o  = out_last_q;

endmodule

[design/slxff_ctrl.sv]
// ----------------------------------------------------------------------------
// slxff_ctrl: controller of the frame filter
// Tracks the frame phase while receiving and sequences the replay of a good
// frame into the output register.
// ----------------------------------------------------------------------------
module slxff_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rx_valid_i,
  output logic            rx_ready_o,
  input  slxff_pkg::sts_t sts_i,
  output slxff_pkg::cmd_t cmd_o
);

  slxff_pkg::state_e state_q, state_d;
  logic              acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slxff_pkg::ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.osel = slxff_pkg::OSEL_SYNC;
    rx_ready_o = (state_q == slxff_pkg::ST_HUNT) || (state_q == slxff_pkg::ST_LEN) ||
                 (state_q == slxff_pkg::ST_DATA) || (state_q == slxff_pkg::ST_CSUM);
    acc        = rx_valid_i && rx_ready_o;
    unique case (state_q)
      slxff_pkg::ST_HUNT: begin
        if (acc && sts_i.sync_hit) state_d = slxff_pkg::ST_LEN;
      end
      slxff_pkg::ST_LEN: begin
        if (acc) begin
          if (sts_i.len_short) begin
            state_d = slxff_pkg::ST_HUNT;
          end else begin
            cmd_o.len_ld = 1'b1;
            state_d      = slxff_pkg::ST_DATA;
          end
        end
      end
      slxff_pkg::ST_DATA: begin
        if (acc) begin
          cmd_o.data_ld = 1'b1;
          if (sts_i.data_done) state_d = slxff_pkg::ST_CSUM;
        end
      end
      slxff_pkg::ST_CSUM: begin
        if (acc) begin
          cmd_o.idx_clr = 1'b1;
          state_d = sts_i.csum_ok ? slxff_pkg::ST_E_SYNC : slxff_pkg::ST_HUNT;
        end
      end
      slxff_pkg::ST_E_SYNC: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          cmd_o.osel   = slxff_pkg::OSEL_SYNC;
          state_d      = slxff_pkg::ST_E_LEN;
        end
      end
      slxff_pkg::ST_E_LEN: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          cmd_o.osel   = slxff_pkg::OSEL_LEN;
          state_d      = slxff_pkg::ST_E_RD;
        end
      end
      slxff_pkg::ST_E_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = slxff_pkg::ST_E_PAY;
      end
      slxff_pkg::ST_E_PAY: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld  = 1'b1;
          cmd_o.osel    = slxff_pkg::OSEL_RAM;
          cmd_o.idx_inc = 1'b1;
          state_d = sts_i.pay_last ? slxff_pkg::ST_E_CSUM : slxff_pkg::ST_E_RD;
        end
      end
      slxff_pkg::ST_E_CSUM: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.osel     = slxff_pkg::OSEL_XOR;
          cmd_o.out_last = 1'b1;
          state_d        = slxff_pkg::ST_HUNT;
        end
      end
      default: state_d = slxff_pkg::ST_HUNT;
    endcase
  end

endmodule

[design/sync_length_xor_frame_filter_core.sv]
// ----------------------------------------------------------------------------
// sync_length_xor_frame_filter_core: sync/length/XOR-checksum frame filter
// Hunts for the sync byte, takes the length, payload and checksum bytes, and
// replays each stored frame whose checksum matches as a stream of words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  rx      | in        | rx_valid_i / rx_ready_o     | rx_byte_i
//  frame   | out       | frame_valid_o / frame_ready_i | frame_byte_o, frame_last_o
//
//  While receiving, one word is taken each cycle.
//  A good frame replays as the sync word, then the length word, then each
//  payload word as a RAM read followed by an output load through the
//  registered read port, then the checksum word.
//  rx_ready_o is low for the whole replay; output stalls stretch it.
//  Reset clears the controller and the output valid; the payload RAM needs no
//  clearing pass, as only entries written in the current frame are replayed.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_filter_core #(
  parameter int unsigned MAX_FRAME_LEN = slxff_pkg::MaxFrameLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       frame_valid_o,
  input  logic       frame_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_last_o
);

  slxff_pkg::cmd_t cmd;
  slxff_pkg::sts_t sts;

  // phase tracking and replay sequencing
  slxff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // counters, checksum, payload store and output word register
  slxff_dp #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rx_byte_i     (rx_byte_i),
    .frame_valid_o (frame_valid_o),
    .frame_ready_i (frame_ready_i),
    .frame_byte_o  (frame_byte_o),
    .frame_last_o  (frame_last_o)
  );

endmodule

[design/slxff_checker.sv]
// ----------------------------------------------------------------------------
// slxff_checker: port-level checks of the frame filter
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
module slxff_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_ready_o,
  input logic [7:0] rx_byte_i,
  input logic       frame_valid_o,
  input logic       frame_ready_i,
  input logic [7:0] frame_byte_o,
  input logic       frame_last_o
);

  // hold a stalled input word
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_i && !rx_ready_o |=> rx_valid_i && $stable(rx_byte_i))
    else $error("stalled input word changed");

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && !frame_ready_i |=>
      frame_valid_o && $stable(frame_byte_o) && $stable(frame_last_o))
    else $error("stalled output word changed");

  // input stays blocked while a frame is still being replayed
  a_replay_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && !frame_last_o |-> !rx_ready_o)
    else $error("input taken during frame replay");

  // input reopens only with the closing word of a frame loaded
  a_ready_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rx_ready_o) |-> frame_valid_o && frame_last_o)
    else $error("input reopened without closing word");

endmodule

bind sync_length_xor_frame_filter_core slxff_checker u_slxff_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rx_valid_i    (rx_valid_i),
  .rx_ready_o    (rx_ready_o),
  .rx_byte_i     (rx_byte_i),
  .frame_valid_o (frame_valid_o),
  .frame_ready_i (frame_ready_i),
  .frame_byte_o  (frame_byte_o),
  .frame_last_o  (frame_last_o)
);

[test/sync_length_xor_frame_filter_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_length_xor_frame_filter_core_tb: self-checking bench of the frame filter
// Feeds byte words through the rx channel and predicts every replayed frame
// word from a behavioral copy of the hunt/length/payload/checksum sequence.
// Both sides idle at random, and a long receiver hold-off forces input stalls.
// ----------------------------------------------------------------------------
module sync_length_xor_frame_filter_core_tb;

  localparam int unsigned ClkHalf    = 4;
  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned IdlePct    = 37;
  localparam int unsigned MemAw      = $clog2(slxff_pkg::MaxFrameLen);
  // drain pause: a full replay of the longest stored frame plus slack
  localparam int unsigned DrainWait  = 2 * slxff_pkg::MaxFrameLen + 16;

  typedef enum logic [1:0] {
    RX_HUNT,
    RX_LEN,
    RX_DATA,
    RX_CSUM
  } rx_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       rx_valid_i = 1'b0;
  logic       rx_ready_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       frame_valid_o;
  logic       frame_ready_i = 1'b0;
  logic [7:0] frame_byte_o;
  logic       frame_last_o;

  // predictor state
  rx_phase_e  rx_phase = RX_HUNT;
  logic [7:0] frm_len = 8'h00;
  logic [7:0] pay_cnt = 8'h00;
  logic [7:0] run_xor = 8'h00;
  logic       oversize = 1'b0;
  logic [7:0] pay_mem [slxff_pkg::MaxFrameLen];

  frame_word_t exp_frame_q[$];

  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned words_sent = 0;
  int unsigned stall_left = 0;
  bit          rx_idle_en = 1'b1;
  bit          rdy_idle_en = 1'b1;

  sync_length_xor_frame_filter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid_i),
    .rx_ready_o    (rx_ready_o),
    .rx_byte_i     (rx_byte_i),
    .frame_valid_o (frame_valid_o),
    .frame_ready_i (frame_ready_i),
    .frame_byte_o  (frame_byte_o),
    .frame_last_o  (frame_last_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("** sync_length_xor_frame_filter_core: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: advance the hunt/length/payload/checksum sequence by one word
  // and queue the replayed frame when its checksum matches.
  // --------------------------------------------------------------------------
  task automatic push_frame_word(input logic [7:0] data, input logic last);
    frame_word_t w;
    w.data = data;
    w.last = last;
    exp_frame_q.push_back(w);
  endtask

  task automatic predict_rx_word(input logic [7:0] b);
    int unsigned n_pay;
    unique case (rx_phase)
      RX_HUNT: begin
        if (b == slxff_pkg::SyncByte) rx_phase = RX_LEN;
      end
      RX_LEN: begin
        // a short length drops the frame; the length word is never a new sync
        if (b < slxff_pkg::MinLen) begin
          rx_phase = RX_HUNT;
        end else begin
          frm_len  = b;
          pay_cnt  = 8'h00;
          run_xor  = slxff_pkg::SyncByte ^ b;
          oversize = (32'(b) > slxff_pkg::MaxFrameLen);
          rx_phase = RX_DATA;
        end
      end
      RX_DATA: begin
        // oversize frames are consumed but never stored
        if (!oversize && 32'(pay_cnt) < slxff_pkg::MaxFrameLen)
          pay_mem[MemAw'(pay_cnt)] = b;
        run_xor = run_xor ^ b;
        pay_cnt = pay_cnt + 8'd1;
        if (pay_cnt >= frm_len - slxff_pkg::HdrBytes) rx_phase = RX_CSUM;
      end
      default: begin
        if (!oversize && run_xor == b) begin
          n_pay = 32'(pay_cnt);
          if (n_pay > slxff_pkg::MaxFrameLen - 32'(slxff_pkg::HdrBytes))
            n_pay = slxff_pkg::MaxFrameLen - 32'(slxff_pkg::HdrBytes);
          push_frame_word(slxff_pkg::SyncByte, 1'b0);
          push_frame_word(frm_len, 1'b0);
          for (int unsigned i = 0; i < n_pay; i++)
            push_frame_word(pay_mem[MemAw'(i)], 1'b0);
          push_frame_word(b, 1'b1);
        end
        rx_phase = RX_HUNT;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sender: offer one word, idle at random beforehand, hold until accepted.
  // Valid is only lowered in an idle cycle, so it never drops and rises in
  // the same step.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b);
    if (rx_idle_en) begin
      while ($urandom_range(99) < IdlePct) begin
        rx_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    predict_rx_word(b);
    words_sent++;
  endtask

  // Send a frame of total length len with random payload (only sync and length
  // below the minimum length); corrupt flips the checksum by a nonzero amount.
  task automatic send_frame(input logic [7:0] len, input bit corrupt);
    logic [7:0] x;
    logic [7:0] p;
    x = slxff_pkg::SyncByte ^ len;
    send_word(slxff_pkg::SyncByte);
    send_word(len);
    if (len < slxff_pkg::MinLen) return;
    for (int unsigned i = 0; i < 32'(len - slxff_pkg::HdrBytes); i++) begin
      p = 8'($urandom);
      x = x ^ p;
      send_word(p);
    end
    if (corrupt) x = x ^ 8'($urandom_range(1, 255));
    send_word(x);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: drive ready (random idle or a counted hold-off) and check each
  // accepted word against the oldest expectation.
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input logic [7:0] want_d, input logic want_l,
                               input bit have_want);
    if (err_cnt < 10) begin
      if (have_want)
        $display("%0t: frame word mismatch: expected byte %h last %b, got byte %h last %b",
                 $realtime, want_d, want_l, frame_byte_o, frame_last_o);
      else
        $display("%0t: unexpected frame word: byte %h last %b",
                 $realtime, frame_byte_o, frame_last_o);
    end
    err_cnt++;
  endtask

  always @(posedge clk_i) begin : frame_sink
    frame_word_t want;
    if (rst_ni && frame_valid_o && frame_ready_i) begin
      if (exp_frame_q.size() == 0) begin
        note_mismatch(8'h00, 1'b0, 1'b0);
      end else begin
        want = exp_frame_q.pop_front();
        if (want.data !== frame_byte_o || want.last !== frame_last_o)
          note_mismatch(want.data, want.last, 1'b1);
      end
    end
    if (stall_left > 0) begin
      frame_ready_i <= 1'b0;
      stall_left--;
    end else if (rdy_idle_en) begin
      frame_ready_i <= ($urandom_range(99) >= IdlePct);
    end else begin
      frame_ready_i <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Noise outside a frame, then lengths below the minimum: drop and resume.
  task automatic test_short_lengths();
    send_word(8'h00);
    send_word(8'hFF);
    send_word(slxff_pkg::SyncByte);
    send_word(8'h00);
    send_word(slxff_pkg::SyncByte);
    send_word(8'h03);
  endtask

  // Sync byte as payload, and a checksum that equals the sync byte.
  task automatic test_sync_in_frame();
    send_word(slxff_pkg::SyncByte);
    send_word(8'h04);
    send_word(slxff_pkg::SyncByte);
    send_word(slxff_pkg::SyncByte ^ 8'h04 ^ slxff_pkg::SyncByte);
    send_word(slxff_pkg::SyncByte);
    send_word(8'h04);
    send_word(8'h04);
    send_word(slxff_pkg::SyncByte);
  endtask

  // Shortest legal frame with an all-ones payload, then a bad checksum.
  task automatic test_min_frame_and_bad_csum();
    send_word(slxff_pkg::SyncByte);
    send_word(slxff_pkg::MinLen);
    send_word(8'hFF);
    send_word(slxff_pkg::SyncByte ^ slxff_pkg::MinLen ^ 8'hFF);
    send_frame(8'd5, 1'b1);
  endtask

  // Largest stored frame.
  task automatic test_max_frame();
    send_frame(8'(slxff_pkg::MaxFrameLen), 1'b0);
  endtask

  // First oversize length with a valid checksum: consumed and dropped, then
  // resync on a good frame.
  task automatic test_oversize_max();
    send_frame(8'(slxff_pkg::MaxFrameLen + 1), 1'b0);
    send_frame(8'd6, 1'b0);
  endtask

  // Mostly well-formed frames with random content, some broken ones and noise.
  task automatic test_random_stream(input int unsigned n_words);
    int unsigned start;
    int unsigned pick;
    logic [7:0]  nz;
    start = words_sent;
    while (words_sent - start < n_words) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_frame(8'($urandom_range(4, 12)), 1'b0);
      end else if (pick < 68) begin
        send_frame(8'($urandom_range(13, slxff_pkg::MaxFrameLen)), 1'b0);
      end else if (pick < 80) begin
        send_frame(8'($urandom_range(4, 16)), 1'b1);
      end else if (pick < 86) begin
        send_frame(8'($urandom_range(0, 3)), 1'b0);
      end else if (pick < 89) begin
        send_frame(8'($urandom_range(slxff_pkg::MaxFrameLen + 1,
                                     slxff_pkg::MaxFrameLen + 12)),
                   1'($urandom_range(1)));
      end else begin
        // keep noise off the sync value so the stream stays aligned
        repeat ($urandom_range(1, 4)) begin
          nz = 8'($urandom);
          if (nz == slxff_pkg::SyncByte) nz = ~nz;
          send_word(nz);
        end
      end
    end
  endtask

  // Both sides at full rate for a long stretch.
  task automatic test_full_rate();
    rx_idle_en  = 1'b0;
    rdy_idle_en = 1'b0;
    repeat (5) send_frame(8'($urandom_range(4, 10)), 1'b0);
    send_frame(8'd7, 1'b1);
    send_frame(8'd9, 1'b0);
    rx_idle_en  = 1'b1;
    rdy_idle_en = 1'b1;
  endtask

  // Hold the receiver off while the sender keeps offering, so replay stalls
  // and the rx side backs up.
  task automatic test_output_stall();
    rx_idle_en = 1'b0;
    stall_left = 400;
    send_frame(8'd12, 1'b0);
    repeat (2) send_frame(8'($urandom_range(4, 8)), 1'b0);
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_lengths();
    test_sync_in_frame();
    test_min_frame_and_bad_csum();
    test_max_frame();
    test_oversize_max();
    test_full_rate();
    test_output_stall();
    test_random_stream(30);

    rx_valid_i <= 1'b0;
    while (exp_frame_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("** sync_length_xor_frame_filter_core: PASSED **");
    end else begin
      $display("** sync_length_xor_frame_filter_core: FAILED **");
    end
    $finish;
  end

endmodule
